/* sv/cht_pkg.sv */
// shared constants and hash unit interface types for the chained hash table
// no dependencies
`default_nettype none

package cht_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 64;
  localparam int ST_W  = 3;

  // number of shift/add or shift/xor rounds in the integer hash
  localparam int HASH_STEPS = 6;

  // result status codes
  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_POOL_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

  // request mode carried in tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_FIND   = 1'b1;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [KEY_W-1:0] hash;
  } hash_rsp_t;

endpackage

`default_nettype wire

/* sv/cht_hash.sv */
// iterative 32-bit integer hash: one shift plus add or xor per cycle
// depends on cht_pkg
`default_nettype none

module cht_hash (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cht_pkg::hash_req_t req,
  output cht_pkg::hash_rsp_t      rsp
);

  localparam logic [2:0] LAST_STEP = 3'(cht_pkg::HASH_STEPS - 1);

  logic [cht_pkg::KEY_W-1:0] x_r, x_nxt;
  logic [2:0]                step_r, step_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [cht_pkg::KEY_W-1:0] opnd;
  logic                      use_add;

  // operand selection for the current round
  always_comb begin
    opnd    = '0;
    use_add = 1'b0;
    case (step_r)
      3'd0: begin
        opnd    = ~(x_r << 15);
        use_add = 1'b1;
      end
      3'd1: opnd = x_r >> 10;
      3'd2: begin
        opnd    = x_r << 3;
        use_add = 1'b1;
      end
      3'd3: opnd = x_r >> 6;
      3'd4: begin
        opnd    = ~(x_r << 11);
        use_add = 1'b1;
      end
      3'd5: opnd = x_r >> 16;
      default: opnd = '0;
    endcase
  end

  // round sequencing
  always_comb begin
    x_nxt    = x_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      x_nxt    = req.key;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = use_add ? (x_r + opnd) : (x_r ^ opnd);
      step_nxt = step_r + 3'd1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.hash = x_r;

endmodule

`default_nettype wire

/* sv/chained_hash_table_insert_find.sv */
// Key/value table with separate chaining, insert or find per item.
// Each item runs the hash rounds, a head read (S_HRD) and compare (S_HCHK),
// then one S_NCHK step per pool node visited, and S_OUT. One item at a time:
// in_tready stays low until the result enters the output register. One chain
// entry is read and compared per cycle from the head and node memories.
// Reset: after rst_n a clearing pass of NUM_BUCKETS cycles empties the head
// memory; in_tready stays low until it ends.
`default_nettype none

module chained_hash_table_insert_find #(
  parameter int NUM_BUCKETS = 128,
  parameter int POOL_NODES  = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,  // key [31:0], value [95:32]
  input  wire logic         in_tuser,  // mode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata, // found_value
  output logic [2:0]        out_tuser  // status
);

  localparam int KW = cht_pkg::KEY_W;
  localparam int VW = cht_pkg::VAL_W;
  localparam int SW = cht_pkg::ST_W;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

  localparam logic [BW-1:0] BMASK = BW'(NUM_BUCKETS - 1);
  localparam logic [BW-1:0] BLAST = BW'(NUM_BUCKETS - 1);
  localparam logic [LW-1:0] POOL_CNT = LW'(POOL_NODES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_HRD  = 3'd3;
  localparam logic [2:0] S_HCHK = 3'd4;
  localparam logic [2:0] S_NCHK = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // memories
  logic          hm_valid [NUM_BUCKETS];
  logic [LW-1:0] hm_link  [NUM_BUCKETS];
  logic [KW-1:0] hm_key   [NUM_BUCKETS];
  logic [VW-1:0] hm_val   [NUM_BUCKETS];
  logic [KW-1:0] nm_key   [POOL_NODES];
  logic [VW-1:0] nm_val   [POOL_NODES];
  logic [LW-1:0] nm_link  [POOL_NODES];

  // control and payload registers
  logic [2:0]    state_r, state_nxt;
  logic [BW-1:0] clr_idx_r, clr_idx_nxt;
  logic [LW-1:0] nodes_taken_r, nodes_taken_nxt;
  logic [BW-1:0] bucket_r, bucket_nxt;
  logic          mode_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;
  logic [SW-1:0] res_status_r, res_status_nxt;
  logic [VW-1:0] res_value_r, res_value_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_status_r;
  logic [VW-1:0] out_value_r;
  logic          out_load;

  // registered memory read data
  logic          hd_valid_q;
  logic [LW-1:0] hd_link_q;
  logic [KW-1:0] hd_key_q;
  logic [VW-1:0] hd_val_q;
  logic [KW-1:0] nd_key_q;
  logic [VW-1:0] nd_val_q;
  logic [LW-1:0] nd_link_q;

  // memory access controls
  logic          hd_rd_en;
  logic          nd_rd_en;
  logic [NW-1:0] nd_raddr;
  logic          hm_meta_we;
  logic          hm_kv_we;
  logic [BW-1:0] hm_waddr;
  logic          hm_wvalid;
  logic [LW-1:0] hm_wlink;
  logic          nm_we;

  // hash unit
  cht_pkg::hash_req_t hreq;
  cht_pkg::hash_rsp_t hrsp;

  cht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  // shared chain entry compare
  logic          cur_hit;
  logic [LW-1:0] cur_link;
  logic [VW-1:0] cur_val;
  logic [LW-1:0] link_m1;

  always_comb begin
    if (state_r == S_HCHK) begin
      cur_hit  = (hd_key_q == key_r);
      cur_link = hd_link_q;
      cur_val  = hd_val_q;
    end else begin
      cur_hit  = (nd_key_q == key_r);
      cur_link = nd_link_q;
      cur_val  = nd_val_q;
    end
  end

  assign link_m1 = cur_link - LW'(1);

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    nodes_taken_nxt = nodes_taken_r;
    bucket_nxt      = bucket_r;
    res_status_nxt  = res_status_r;
    res_value_nxt   = res_value_r;
    hreq.start      = 1'b0;
    hreq.key        = in_tdata[KW-1:0];
    hd_rd_en        = 1'b0;
    nd_rd_en        = 1'b0;
    nd_raddr        = link_m1[NW-1:0];
    hm_meta_we      = 1'b0;
    hm_kv_we        = 1'b0;
    hm_waddr        = bucket_r;
    hm_wvalid       = 1'b1;
    hm_wlink        = '0;
    nm_we           = 1'b0;
    out_load        = 1'b0;

    case (state_r)
      S_CLR: begin
        hm_meta_we  = 1'b1;
        hm_waddr    = clr_idx_r;
        hm_wvalid   = 1'b0;
        clr_idx_nxt = clr_idx_r + BW'(1);
        if (clr_idx_r == BLAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          hreq.start = 1'b1;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        if (hrsp.done) begin
          bucket_nxt = hrsp.hash[BW-1:0] & BMASK;
          state_nxt  = S_HRD;
        end
      end
      S_HRD: begin
        hd_rd_en  = 1'b1;
        state_nxt = S_HCHK;
      end
      S_HCHK, S_NCHK: begin
        res_value_nxt = '0;
        if (state_r == S_HCHK && !hd_valid_q) begin
          // empty bucket: fill the head slot on insert
          state_nxt = S_OUT;
          if (mode_r == cht_pkg::MODE_FIND) begin
            res_status_nxt = cht_pkg::ST_NOT_FOUND;
          end else begin
            hm_meta_we     = 1'b1;
            hm_kv_we       = 1'b1;
            hm_wlink       = '0;
            res_status_nxt = cht_pkg::ST_INSERTED;
          end
        end else if (cur_hit) begin
          state_nxt = S_OUT;
          if (mode_r == cht_pkg::MODE_FIND) begin
            res_status_nxt = cht_pkg::ST_FOUND;
            res_value_nxt  = cur_val;
          end else begin
            res_status_nxt = cht_pkg::ST_DUPLICATE;
          end
        end else if (cur_link != '0) begin
          // follow the chain one node
          nd_rd_en  = 1'b1;
          state_nxt = S_NCHK;
        end else begin
          // end of chain, key absent
          state_nxt = S_OUT;
          if (mode_r == cht_pkg::MODE_FIND) begin
            res_status_nxt = cht_pkg::ST_NOT_FOUND;
          end else if (nodes_taken_r == POOL_CNT) begin
            res_status_nxt = cht_pkg::ST_POOL_FULL;
          end else begin
            // new node goes right after the head
            nm_we           = 1'b1;
            hm_meta_we      = 1'b1;
            hm_wlink        = nodes_taken_r + LW'(1);
            nodes_taken_nxt = nodes_taken_r + LW'(1);
            res_status_nxt  = cht_pkg::ST_INSERTED;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_idx_r     <= '0;
      nodes_taken_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      nodes_taken_r <= nodes_taken_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bucket_r     <= bucket_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (hreq.start) begin
      mode_r <= in_tuser;
      key_r  <= in_tdata[KW-1:0];
      val_r  <= in_tdata[KW+VW-1:KW];
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  // head memory
  always_ff @(posedge clk) begin
    if (hm_meta_we) begin
      hm_valid[hm_waddr] <= hm_wvalid;
      hm_link[hm_waddr]  <= hm_wlink;
    end
    if (hm_kv_we) begin
      hm_key[hm_waddr] <= key_r;
      hm_val[hm_waddr] <= val_r;
    end
    if (hd_rd_en) begin
      hd_valid_q <= hm_valid[bucket_r];
      hd_link_q  <= hm_link[bucket_r];
      hd_key_q   <= hm_key[bucket_r];
      hd_val_q   <= hm_val[bucket_r];
    end
  end

  // node pool memory
  always_ff @(posedge clk) begin
    if (nm_we) begin
      nm_key[nodes_taken_r[NW-1:0]]  <= key_r;
      nm_val[nodes_taken_r[NW-1:0]]  <= val_r;
      nm_link[nodes_taken_r[NW-1:0]] <= hd_link_q;
    end
    if (nd_rd_en) begin
      nd_key_q  <= nm_key[nd_raddr];
      nd_val_q  <= nm_val[nd_raddr];
      nd_link_q <= nm_link[nd_raddr];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire
